// ===== src/hbrs_pkg.sv =====
// Shared constants and types for the H-bridge reversal sequencer.
package hbrs_pkg;

  localparam int CHANNEL_COUNT = 2;
  localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CNT_W = $clog2(CHANNEL_COUNT + 1);

  localparam logic [6:0] MAX_MAGNITUDE = 7'd100;

  localparam logic CMD_SET_DRIVE = 1'b0;
  localparam logic CMD_TICK      = 1'b1;

  localparam logic KIND_PWM = 1'b0;
  localparam logic KIND_DIR = 1'b1;

  localparam logic [1:0] PHASE_NORMAL    = 2'd0;
  localparam logic [1:0] PHASE_WAIT      = 2'd1;
  localparam logic [1:0] PHASE_SET_DIR   = 2'd2;
  localparam logic [1:0] PHASE_SET_LEVEL = 2'd3;

  typedef struct packed {
    logic       chan;
    logic       kind;
    logic [6:0] pwm;
    logic       dir;
  } write_word_t;

endpackage

// ===== src/hbridge_reversal_sequencer.sv =====
// H-bridge reversal sequencer: per-channel drive state and write generation.
//
// Usage:
//  - Input channel (in_valid/in_ready): one word is either a set-drive command
//    (command=0, channel, signed drive_level) or a timer tick (command=1).
//  - Output channel (out_valid/out_ready): one word per hardware write, with
//    out_channel, write_kind (PWM or direction pin), pwm_value, dir_value and
//    last, which marks the final write caused by one input word.
//  - An input word is evaluated in the cycle it is accepted; channel state is
//    updated at that edge and its writes are loaded into a small result
//    buffer (up to CHANNEL_COUNT words). The first write is offered in the
//    next cycle.
//  - Throughput: a word producing k writes holds the buffer until all k are
//    taken (k is 0..CHANNEL_COUNT). in_ready is high when the buffer is empty or
//    its final word is being taken, so a one-write command can follow every
//    cycle while out_ready stays high. The buffer drain, one word per cycle
//    while out_ready is high, sets the rate.
//  - Receiver stall: the buffered word holds on the outputs and in_ready stays low.
//  - Reset (rst, synchronous): every channel goes to direction open, level 0,
//    phase normal; the result buffer empties.
module hbridge_reversal_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic       channel,
  input  logic [7:0] drive_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_channel,
  output logic       write_kind,
  output logic [6:0] pwm_value,
  output logic       dir_value,
  output logic       last
);
  import hbrs_pkg::*;

  // Per-channel state
  logic       chan_direction      [CHANNEL_COUNT];
  logic [6:0] chan_target_level   [CHANNEL_COUNT];
  logic [1:0] chan_phase          [CHANNEL_COUNT];
  logic       chan_direction_next [CHANNEL_COUNT];
  logic [6:0] chan_target_level_next [CHANNEL_COUNT];
  logic [1:0] chan_phase_next     [CHANNEL_COUNT];

  // Result buffer: holds the writes of one input word
  write_word_t res_buf [CHANNEL_COUNT];
  write_word_t res_buf_next [CHANNEL_COUNT];
  logic [CNT_W-1:0] num;
  logic [CNT_W-1:0] num_next;
  logic [CH_W-1:0]  hd;

  logic in_fire, out_fire;

  assign out_valid = (num != '0);
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (num == '0) || ((num == CNT_W'(1)) && out_ready);
  assign in_fire   = in_valid && in_ready;

  assign out_channel = res_buf[hd].chan;
  assign write_kind  = res_buf[hd].kind;
  assign pwm_value   = res_buf[hd].pwm;
  assign dir_value   = res_buf[hd].dir;
  assign last        = (num == CNT_W'(1));

  // Level decode: sign gives direction, magnitude saturates at 100
  logic [7:0] mag8;
  logic [6:0] mag;
  logic       dir;
  logic       ch_ok;
  logic [CH_W-1:0] cidx;

  always_comb begin
    mag8  = drive_level[7] ? (8'd0 - drive_level) : drive_level;
    mag   = (mag8 > {1'b0, MAX_MAGNITUDE}) ? MAX_MAGNITUDE : mag8[6:0];
    dir   = !drive_level[7] && (drive_level != 8'd0);
    ch_ok = (int'(channel) < CHANNEL_COUNT);
    cidx  = CH_W'(channel);
  end

  always_comb begin
    logic [CNT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      chan_direction_next[i]    = chan_direction[i];
      chan_target_level_next[i] = chan_target_level[i];
      chan_phase_next[i]        = chan_phase[i];
      res_buf_next[i]           = '0;
    end

    if (command == CMD_SET_DRIVE) begin
      if (ch_ok && !(mag == chan_target_level[cidx] && dir == chan_direction[cidx])) begin
        chan_target_level_next[cidx] = mag;
        if (dir == chan_direction[cidx]) begin
          // magnitude-only change; while reversing, the sequence writes it later
          if (chan_phase[cidx] == PHASE_NORMAL) begin
            res_buf_next[0] = '{chan: channel, kind: KIND_PWM, pwm: mag, dir: 1'b0};
            pos = CNT_W'(1);
          end
        end else begin
          chan_direction_next[cidx] = dir;
          chan_phase_next[cidx]     = PHASE_WAIT;
          res_buf_next[0] = '{chan: channel, kind: KIND_PWM, pwm: 7'd0, dir: 1'b0};
          pos = CNT_W'(1);
        end
      end
    end else begin
      // tick: advance every reversing channel, writes packed in channel order
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        case (chan_phase[i])
          PHASE_WAIT: chan_phase_next[i] = PHASE_SET_DIR;
          PHASE_SET_DIR: begin
            chan_phase_next[i] = PHASE_SET_LEVEL;
            res_buf_next[pos[CH_W-1:0]] = '{chan: i[0], kind: KIND_DIR, pwm: 7'd0,
                                             dir: chan_direction[i]};
            pos = pos + CNT_W'(1);
          end
          PHASE_SET_LEVEL: begin
            chan_phase_next[i] = PHASE_NORMAL;
            res_buf_next[pos[CH_W-1:0]] = '{chan: i[0], kind: KIND_PWM,
                                             pwm: chan_target_level[i], dir: 1'b0};
            pos = pos + CNT_W'(1);
          end
          default: ;
        endcase
      end
    end
    num_next = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_direction[i]    <= 1'b1;
        chan_target_level[i] <= 7'd0;
        chan_phase[i]        <= PHASE_NORMAL;
      end
      num <= '0;
      hd  <= '0;
    end else if (in_fire) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_direction[i]    <= chan_direction_next[i];
        chan_target_level[i] <= chan_target_level_next[i];
        chan_phase[i]        <= chan_phase_next[i];
      end
      num <= num_next;
      hd  <= '0;
    end else if (out_fire) begin
      num <= num - CNT_W'(1);
      hd  <= hd + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        res_buf[i] <= res_buf_next[i];
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (num == '0) || (num == CNT_W'(1) && out_fire))
    else $error("input accepted over pending result words");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(num) <= CHANNEL_COUNT)
    else $error("result count beyond channel count");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last && !in_fire) |=> !out_valid)
    else $error("output still valid after final word taken");

  a_tick_setdir: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == CMD_TICK && chan_phase[0] == PHASE_SET_DIR)
      |=> (chan_phase[0] == PHASE_SET_LEVEL) && out_valid)
    else $error("tick did not advance channel 0 to level phase");
`endif

endmodule

// ===== dv/tb_hbridge_reversal_sequencer.sv =====
// Testbench for hbridge_reversal_sequencer: random bursty stimulus, per-channel predictor.
module tb_hbridge_reversal_sequencer;
  import hbrs_pkg::*;

  localparam int RANDOM_WORDS   = 1050;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  // one command word as it goes onto the input channel
  typedef struct packed {
    logic       command;
    logic       channel;
    logic [7:0] level;
  } bridge_cmd_t;

  // one expected hardware write, last flag included
  typedef struct packed {
    logic       chan;
    logic       kind;
    logic [6:0] pwm;
    logic       dir;
    logic       last;
  } bridge_write_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = CMD_SET_DRIVE;
  logic       channel = 1'b0;
  logic [7:0] drive_level = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_channel;
  logic       write_kind;
  logic [6:0] pwm_value;
  logic       dir_value;
  logic       last;

  hbridge_reversal_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .channel(channel),
    .drive_level(drive_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_channel(out_channel),
    .write_kind(write_kind),
    .pwm_value(pwm_value),
    .dir_value(dir_value),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of every channel's direction, target level and phase
  // ---------------------------------------------------------------------------
  logic       chan_dir_q   [CHANNEL_COUNT];
  logic [6:0] chan_level_q [CHANNEL_COUNT];
  logic [1:0] chan_phase_q [CHANNEL_COUNT];

  bridge_cmd_t   cmd_queue[$];       // words not yet presented
  bridge_write_t pending_writes[$];  // writes predicted, not yet seen

  int error_count    = 0;
  int words_accepted = 0;
  int idle_cycles    = 0;

  initial begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      chan_dir_q[i]   = 1'b1;
      chan_level_q[i] = 7'd0;
      chan_phase_q[i] = PHASE_NORMAL;
    end
  end

  // Apply one accepted word to the channel state and queue the writes it causes.
  function automatic void predict_bridge_writes(bridge_cmd_t c);
    bridge_write_t writes[$];
    bridge_write_t w;
    logic          new_dir;
    int            mag;
    int            ch;
    ch = int'(c.channel);
    if (c.command == CMD_SET_DRIVE) begin
      if (ch >= CHANNEL_COUNT) return;
      // split the signed level; negative magnitudes taken as 256 - raw
      if (c.level[7]) begin
        new_dir = 1'b0;
        mag     = 256 - int'(c.level);
      end else begin
        new_dir = (c.level != 8'd0);
        mag     = int'(c.level);
      end
      if (mag > int'(MAX_MAGNITUDE)) mag = int'(MAX_MAGNITUDE);
      if (mag == int'(chan_level_q[ch]) && new_dir == chan_dir_q[ch]) return;
      w = '0;
      w.chan = c.channel;
      w.kind = KIND_PWM;
      if (new_dir == chan_dir_q[ch]) begin
        chan_level_q[ch] = mag[6:0];
        // while reversing the level is only stored; the sequence writes it
        if (chan_phase_q[ch] == PHASE_NORMAL) begin
          w.pwm = mag[6:0];
          writes.push_back(w);
        end
      end else begin
        // direction flip: drop PWM to zero and restart the reversal
        chan_dir_q[ch]   = new_dir;
        chan_level_q[ch] = mag[6:0];
        chan_phase_q[ch] = PHASE_WAIT;
        writes.push_back(w);
      end
    end else begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        w = '0;
        w.chan = i[0];
        case (chan_phase_q[i])
          PHASE_WAIT: begin
            chan_phase_q[i] = PHASE_SET_DIR;
          end
          PHASE_SET_DIR: begin
            chan_phase_q[i] = PHASE_SET_LEVEL;
            w.kind = KIND_DIR;
            w.dir  = chan_dir_q[i];
            writes.push_back(w);
          end
          PHASE_SET_LEVEL: begin
            chan_phase_q[i] = PHASE_NORMAL;
            w.kind = KIND_PWM;
            w.pwm  = chan_level_q[i];
            writes.push_back(w);
          end
          default: ;
        endcase
      end
    end
    if (writes.size() > 0) writes[writes.size() - 1].last = 1'b1;
    foreach (writes[i]) pending_writes.push_back(writes[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic queue_cmd(input logic cmd, input logic ch, input logic [7:0] lvl);
    bridge_cmd_t c;
    c.command = cmd;
    c.channel = ch;
    c.level   = lvl;
    cmd_queue.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of back-to-back words with random gaps between bursts
  // ---------------------------------------------------------------------------
  int          burst_left = 4;
  int          gap_left   = 0;
  bridge_cmd_t next_cmd;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bridge_writes('{command, channel, drive_level});
        words_accepted++;
      end
      // the slot is free once the current word is taken or nothing is shown
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          next_cmd    = cmd_queue.pop_front();
          command     <= next_cmd.command;
          channel     <= next_cmd.channel;
          drive_level <= next_cmd.level;
          in_valid    <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            // a zero gap now and then gives long stretches with no idling
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: rotating ready pattern, compares each write with the oldest prediction
  // ---------------------------------------------------------------------------
  logic [7:0]    ready_pattern = 8'hFF;
  int            pattern_age   = 0;
  bridge_write_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write ch=%0d kind=%0d pwm=%0d dir=%0d last=%0d",
                                    out_channel, write_kind, pwm_value, dir_value, last));
        end else begin
          want = pending_writes.pop_front();
          if (out_channel !== want.chan)
            report_mismatch($sformatf("out_channel %0d, want %0d", out_channel, want.chan));
          if (write_kind !== want.kind)
            report_mismatch($sformatf("write_kind %0d, want %0d", write_kind, want.kind));
          if (pwm_value !== want.pwm)
            report_mismatch($sformatf("pwm_value %0d, want %0d", pwm_value, want.pwm));
          if (dir_value !== want.dir)
            report_mismatch($sformatf("dir_value %0d, want %0d", dir_value, want.dir));
          if (last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", last, want.last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      // new stall pattern every so often; some phases never stall
      pattern_age++;
      if (pattern_age >= 50) begin
        pattern_age = 0;
        ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
      end
      out_ready     <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
    end
  end

  // watchdog: too long with no word moving on either channel
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  int          total_words;
  int          pick;
  int          lvl_int;
  logic [7:0]  prev_level [2];

  initial begin
    // directed: saturation, no-change, reversal, level change mid-reversal
    queue_cmd(CMD_SET_DRIVE, 1'b0, 8'sd50);    // magnitude-only write
    queue_cmd(CMD_SET_DRIVE, 1'b0, 8'sd50);    // no change, no write
    queue_cmd(CMD_SET_DRIVE, 1'b0, 8'sd127);   // saturates to 100
    queue_cmd(CMD_SET_DRIVE, 1'b0, 8'sd100);   // same after saturation
    queue_cmd(CMD_SET_DRIVE, 1'b0, 8'h80);     // -128: flip to close, saturated
    queue_cmd(CMD_SET_DRIVE, 1'b0, -8'sd30);   // level change while reversing
    queue_cmd(CMD_SET_DRIVE, 1'b1, 8'sd0);     // zero closes: flip on channel 1
    queue_cmd(CMD_TICK, 1'b1, 8'hFF);          // both wait
    queue_cmd(CMD_TICK, 1'b0, 8'h00);          // two direction writes
    queue_cmd(CMD_TICK, 1'b1, 8'h7F);          // two level writes
    queue_cmd(CMD_TICK, 1'b0, 8'h55);          // idle tick
    queue_cmd(CMD_SET_DRIVE, 1'b1, -8'sd100);
    queue_cmd(CMD_SET_DRIVE, 1'b1, 8'sd1);
    queue_cmd(CMD_TICK, 1'b0, 8'hAA);
    queue_cmd(CMD_SET_DRIVE, 1'b0, -8'sd101);  // saturates on the negative side
    queue_cmd(CMD_TICK, 1'b1, 8'h01);
    queue_cmd(CMD_SET_DRIVE, 1'b1, -8'sd1);    // flip back during the level phase
    queue_cmd(CMD_TICK, 1'b0, 8'h00);
    queue_cmd(CMD_TICK, 1'b0, 8'h00);
    queue_cmd(CMD_TICK, 1'b0, 8'h00);
    queue_cmd(CMD_SET_DRIVE, 1'b0, 8'sd0);
    queue_cmd(CMD_SET_DRIVE, 1'b0, 8'sd101);
    queue_cmd(CMD_TICK, 1'b1, 8'h80);
    queue_cmd(CMD_TICK, 1'b1, 8'h80);
    queue_cmd(CMD_TICK, 1'b1, 8'h80);

    prev_level[0] = 8'd0;
    prev_level[1] = 8'd0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // tick; channel and level are noise here
        queue_cmd(CMD_TICK, 1'($urandom()), 8'($urandom()));
      end else begin
        next_cmd.channel = 1'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          next_cmd.level = prev_level[next_cmd.channel];           // repeat
        end else if (pick < 25) begin
          next_cmd.level = -prev_level[next_cmd.channel];          // flip sign
        end else if (pick < 37) begin
          next_cmd.level = 8'($urandom());                         // full byte
        end else begin
          lvl_int = int'($urandom_range(0, 200)) - 100;
          next_cmd.level = lvl_int[7:0];
        end
        prev_level[next_cmd.channel] = next_cmd.level;
        queue_cmd(CMD_SET_DRIVE, next_cmd.channel, next_cmd.level);
      end
    end
    total_words = cmd_queue.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (words_accepted < total_words) @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0)
      report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hbrs_pkg.sv
src/hbridge_reversal_sequencer.sv
dv/tb_hbridge_reversal_sequencer.sv
